// File: rtl/bdlpr_pkg.sv
// Shared types and constants for the button debounce / long press / repeat block.
package bdlpr_pkg;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;
    localparam int THRESH_W   = 16;
    localparam int EN_W       = 3;

    typedef enum logic [2:0] {
        REG_DEBOUNCE     = 3'd0,
        REG_LONG_PRESS   = 3'd1,
        REG_REPEAT_DELAY = 3'd2,
        REG_REPEAT_RATE  = 3'd3,
        REG_LP_ENABLE    = 3'd4,
        REG_AR_ENABLE    = 3'd5
    } reg_idx_t;

    localparam logic [THRESH_W-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [THRESH_W-1:0] LONG_PRESS_RESET   = 16'd1000;
    localparam logic [THRESH_W-1:0] REPEAT_DELAY_RESET = 16'd500;
    localparam logic [THRESH_W-1:0] REPEAT_RATE_RESET  = 16'd150;
    localparam logic [EN_W-1:0]     LP_ENABLE_RESET    = 3'd4;
    localparam logic [EN_W-1:0]     AR_ENABLE_RESET    = 3'd3;

    typedef struct packed {
        logic [THRESH_W-1:0] debounce;
        logic [THRESH_W-1:0] long_press;
        logic [THRESH_W-1:0] repeat_delay;
        logic [THRESH_W-1:0] repeat_rate;
    } thresh_t;

    typedef struct packed {
        logic short_evt;
        logic repeat_evt;
        logic long_evt;
        logic stable;
    } lane_evt_t;

endpackage

// File: rtl/bdlpr_cfg.sv
// APB-style configuration register file.
module bdlpr_cfg #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bdlpr_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [bdlpr_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [bdlpr_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                   pready,
    output bdlpr_pkg::thresh_t                     thresh,
    output logic [BUTTON_COUNT-1:0]                lp_en,
    output logic [BUTTON_COUNT-1:0]                ar_en
);

    bdlpr_pkg::thresh_t            thresh_reg;
    bdlpr_pkg::thresh_t            thresh_next;
    logic [BUTTON_COUNT-1:0]       lp_en_reg;
    logic [BUTTON_COUNT-1:0]       lp_en_next;
    logic [BUTTON_COUNT-1:0]       ar_en_reg;
    logic [BUTTON_COUNT-1:0]       ar_en_next;
    logic                          wr;
    logic [2:0]                    idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[4:2];

    always_comb
    begin
        thresh_next = thresh_reg;
        lp_en_next  = lp_en_reg;
        ar_en_next  = ar_en_reg;
        if (wr)
        begin
            case (idx)
                bdlpr_pkg::REG_DEBOUNCE:
                    thresh_next.debounce = pwdata[bdlpr_pkg::THRESH_W-1:0];
                bdlpr_pkg::REG_LONG_PRESS:
                    thresh_next.long_press = pwdata[bdlpr_pkg::THRESH_W-1:0];
                bdlpr_pkg::REG_REPEAT_DELAY:
                    thresh_next.repeat_delay = pwdata[bdlpr_pkg::THRESH_W-1:0];
                bdlpr_pkg::REG_REPEAT_RATE:
                    thresh_next.repeat_rate = pwdata[bdlpr_pkg::THRESH_W-1:0];
                bdlpr_pkg::REG_LP_ENABLE:
                    lp_en_next = pwdata[BUTTON_COUNT-1:0];
                bdlpr_pkg::REG_AR_ENABLE:
                    ar_en_next = pwdata[BUTTON_COUNT-1:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bdlpr_pkg::REG_DEBOUNCE:     prdata = 32'(thresh_reg.debounce);
            bdlpr_pkg::REG_LONG_PRESS:   prdata = 32'(thresh_reg.long_press);
            bdlpr_pkg::REG_REPEAT_DELAY: prdata = 32'(thresh_reg.repeat_delay);
            bdlpr_pkg::REG_REPEAT_RATE:  prdata = 32'(thresh_reg.repeat_rate);
            bdlpr_pkg::REG_LP_ENABLE:    prdata = 32'(lp_en_reg);
            bdlpr_pkg::REG_AR_ENABLE:    prdata = 32'(ar_en_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thresh_reg.debounce     <= bdlpr_pkg::DEBOUNCE_RESET;
            thresh_reg.long_press   <= bdlpr_pkg::LONG_PRESS_RESET;
            thresh_reg.repeat_delay <= bdlpr_pkg::REPEAT_DELAY_RESET;
            thresh_reg.repeat_rate  <= bdlpr_pkg::REPEAT_RATE_RESET;
            lp_en_reg               <= BUTTON_COUNT'(bdlpr_pkg::LP_ENABLE_RESET);
            ar_en_reg               <= BUTTON_COUNT'(bdlpr_pkg::AR_ENABLE_RESET);
        end
        else
        begin
            thresh_reg <= thresh_next;
            lp_en_reg  <= lp_en_next;
            ar_en_reg  <= ar_en_next;
        end
    end

    assign thresh = thresh_reg;
    assign lp_en  = lp_en_reg;
    assign ar_en  = ar_en_reg;

endmodule

// File: rtl/bdlpr_lane.sv
// Per-button debounce, press, long press and auto-repeat core.
module bdlpr_lane #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [TIME_WIDTH-1:0]     now,
    input  logic                      raw,
    input  logic                      lp_en,
    input  logic                      ar_en,
    input  bdlpr_pkg::thresh_t        thresh,
    output bdlpr_pkg::lane_evt_t      evt
);

    logic [TIME_WIDTH-1:0] lock_start_reg, lock_start_next;
    logic [TIME_WIDTH-1:0] hold_start_reg, hold_start_next;
    logic [TIME_WIDTH-1:0] last_rep_reg, last_rep_next;
    logic                  level_reg, level_next;
    logic                  fired_reg, fired_next;
    logic                  repeating_reg, repeating_next;

    logic [TIME_WIDTH-1:0] lock_el;
    logic [TIME_WIDTH-1:0] hold_el;
    logic [TIME_WIDTH-1:0] rep_el;
    logic                  change;
    logic                  press;
    logic                  release_acc;
    logic                  fired_cur;
    logic                  repeating_cur;
    logic                  long_hit;
    logic                  rep_hit;
    logic                  first_rep;

    assign lock_el     = now - lock_start_reg;
    assign change      = (lock_el >= TIME_WIDTH'(thresh.debounce)) && (raw != level_reg);
    assign press       = change && !raw;
    assign release_acc = change && raw;

    // a fresh press restarts the hold and repeat timers at zero elapsed
    assign hold_el       = press ? '0 : (now - hold_start_reg);
    assign rep_el        = press ? '0 : (now - last_rep_reg);
    assign fired_cur     = press ? 1'b0 : fired_reg;
    assign repeating_cur = change ? 1'b0 : repeating_reg;
    assign level_next    = change ? raw : level_reg;

    assign long_hit  = !level_next && lp_en && !fired_cur
                       && (hold_el >= TIME_WIDTH'(thresh.long_press));
    assign first_rep = !level_next && ar_en && !repeating_cur
                       && (hold_el >= TIME_WIDTH'(thresh.repeat_delay));
    assign rep_hit   = first_rep || (!level_next && ar_en && repeating_cur
                       && (rep_el >= TIME_WIDTH'(thresh.repeat_rate)));

    assign lock_start_next = change ? now : lock_start_reg;
    assign hold_start_next = press ? now : hold_start_reg;
    assign last_rep_next   = (press || rep_hit) ? now : last_rep_reg;
    assign fired_next      = fired_cur || long_hit;
    assign repeating_next  = repeating_cur || first_rep;

    assign evt.short_evt  = (press && !lp_en) || (release_acc && lp_en && !fired_reg);
    assign evt.repeat_evt = rep_hit;
    assign evt.long_evt   = long_hit;
    assign evt.stable     = level_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_start_reg <= '0;
            hold_start_reg <= '0;
            last_rep_reg   <= '0;
            level_reg      <= 1'b1;
            fired_reg      <= 1'b0;
            repeating_reg  <= 1'b0;
        end
        else if (advance)
        begin
            lock_start_reg <= lock_start_next;
            hold_start_reg <= hold_start_next;
            last_rep_reg   <= last_rep_next;
            level_reg      <= level_next;
            fired_reg      <= fired_next;
            repeating_reg  <= repeating_next;
        end
    end

endmodule

// File: rtl/bdlpr_merge.sv
// Gathers lane results into event vectors and buffers them in a two-entry output stage.
module bdlpr_merge #(
    parameter int BUTTON_COUNT = 3
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  logic                                        load,
    input  bdlpr_pkg::lane_evt_t [BUTTON_COUNT-1:0]     lane_evt,
    output logic                                        full,
    output logic                                        event_valid,
    input  logic                                        event_stall,
    output logic [BUTTON_COUNT-1:0]                     short_events,
    output logic [BUTTON_COUNT-1:0]                     repeat_events,
    output logic [BUTTON_COUNT-1:0]                     long_events,
    output logic [BUTTON_COUNT-1:0]                     stable_levels
);

    localparam int RES_W = 4 * BUTTON_COUNT;

    logic [RES_W-1:0] packed_res;
    logic [RES_W-1:0] out_data_reg;
    logic [RES_W-1:0] skid_data_reg;
    logic             out_valid_reg, out_valid_next;
    logic             skid_valid_reg, skid_valid_next;
    logic             out_fire;

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            packed_res[i]                  = lane_evt[i].short_evt;
            packed_res[BUTTON_COUNT + i]   = lane_evt[i].repeat_evt;
            packed_res[2*BUTTON_COUNT + i] = lane_evt[i].long_evt;
            packed_res[3*BUTTON_COUNT + i] = lane_evt[i].stable;
        end
    end

    assign out_fire = out_valid_reg && !event_stall;
    assign full     = skid_valid_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_next = 1'b0;
        end
        else if (load)
        begin
            if (out_valid_reg && !out_fire)
                skid_valid_next = 1'b1;
            else
                out_valid_next = 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
                out_data_reg <= skid_data_reg;
        end
        else if (load)
        begin
            if (out_valid_reg && !out_fire)
                skid_data_reg <= packed_res;
            else
                out_data_reg <= packed_res;
        end
    end

    assign event_valid   = out_valid_reg;
    assign short_events  = out_data_reg[BUTTON_COUNT-1:0];
    assign repeat_events = out_data_reg[2*BUTTON_COUNT-1:BUTTON_COUNT];
    assign long_events   = out_data_reg[3*BUTTON_COUNT-1:2*BUTTON_COUNT];
    assign stable_levels = out_data_reg[4*BUTTON_COUNT-1:3*BUTTON_COUNT];

endmodule

// File: rtl/button_debounce_long_press_repeat.sv
// Top level: debounced buttons with short press, long press and auto-repeat events.
// One transaction on the tick channel is one time tick carrying the raw active-low
// button levels; each produces exactly one result transaction with one-tick event
// pulses and the debounced levels. A tick is taken in every cycle unless tick_stall
// is high: each button has its own lane whose timers are a subtract and compare
// against a count of accepted ticks, all evaluated in the cycle the tick is taken.
// The result is registered into a two-entry output buffer that drives the event
// channel; tick_stall rises only while both entries hold untaken results. The user
// must write configuration over the APB port while the block is idle; not enforced.
module button_debounce_long_press_repeat #(
    parameter int BUTTON_COUNT = 3,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bdlpr_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [bdlpr_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [bdlpr_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready,
    input  logic                                  tick_valid,
    output logic                                  tick_stall,
    input  logic [BUTTON_COUNT-1:0]               raw_levels,
    output logic                                  event_valid,
    input  logic                                  event_stall,
    output logic [BUTTON_COUNT-1:0]               short_events,
    output logic [BUTTON_COUNT-1:0]               repeat_events,
    output logic [BUTTON_COUNT-1:0]               long_events,
    output logic [BUTTON_COUNT-1:0]               stable_levels
);

    bdlpr_pkg::thresh_t                       thresh;
    logic [BUTTON_COUNT-1:0]                  lp_en;
    logic [BUTTON_COUNT-1:0]                  ar_en;
    bdlpr_pkg::lane_evt_t [BUTTON_COUNT-1:0]  lane_evt;
    logic                                     full;
    logic                                     advance;
    logic [TIME_WIDTH-1:0]                    tick_time_reg;
    logic [TIME_WIDTH-1:0]                    tick_time_next;

    assign tick_stall     = full;
    assign advance        = tick_valid && !full;
    assign tick_time_next = tick_time_reg + TIME_WIDTH'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tick_time_reg <= '0;
        else if (advance)
            tick_time_reg <= tick_time_next;
    end

    bdlpr_cfg #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .thresh  (thresh),
        .lp_en   (lp_en),
        .ar_en   (ar_en)
    );

    for (genvar g = 0; g < BUTTON_COUNT; g++)
    begin : g_lane
        bdlpr_lane #(
            .TIME_WIDTH (TIME_WIDTH)
        ) u_lane (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .now     (tick_time_reg),
            .raw     (raw_levels[g]),
            .lp_en   (lp_en[g]),
            .ar_en   (ar_en[g]),
            .thresh  (thresh),
            .evt     (lane_evt[g])
        );
    end

    bdlpr_merge #(
        .BUTTON_COUNT (BUTTON_COUNT)
    ) u_merge (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (advance),
        .lane_evt      (lane_evt),
        .full          (full),
        .event_valid   (event_valid),
        .event_stall   (event_stall),
        .short_events  (short_events),
        .repeat_events (repeat_events),
        .long_events   (long_events),
        .stable_levels (stable_levels)
    );

endmodule
